// ===== rtl/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bbc_pkg: shared types and helpers for the bounding box crop block
// Payload structs, register indices, reset values and the axis padding math.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

  // Fixed field widths
  localparam int COORD_W = 10;   // coordinate / size fields of a result
  localparam int SIZE_W  = 11;   // frame size registers
  localparam int PAD_W   = 7;    // padding register
  localparam int IDX_W   = 2;    // configuration register index
  localparam int HW_CAP  = 1024; // largest frame side the fields can carry

  // Configuration register indices
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_CROP_PADDING = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd320;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd240;
  localparam logic [PAD_W-1:0]  RST_CROP_PADDING = 7'd30;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Input transaction payload
  typedef struct packed {
    logic pixel_on;
  } pixel_t;

  // Result transaction payload
  typedef struct packed {
    logic               object_found;
    logic [COORD_W-1:0] crop_x;
    logic [COORD_W-1:0] crop_y;
    logic [COORD_W-1:0] crop_width;
    logic [COORD_W-1:0] crop_height;
  } box_t;

  // Frame summary handed from the tracker to the padding stage
  typedef struct packed {
    logic [COORD_W-1:0] least_column;
    logic [COORD_W-1:0] greatest_column;
    logic [COORD_W-1:0] least_row;
    logic [COORD_W-1:0] greatest_row;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [PAD_W-1:0]   padding;
  } snap_t;

  // One padded axis
  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } axis_t;

  // Clamp a size register to 1 .. top
  function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > top) begin
      res = top;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Move both edges out by the padding, clamping them to 0 and extent-1
  function automatic axis_t pad_axis(input logic [COORD_W-1:0] lo,
                                     input logic [COORD_W-1:0] hi,
                                     input logic [SIZE_W-1:0]  extent,
                                     input logic [PAD_W-1:0]   pad);
    axis_t             res;
    logic [SIZE_W-1:0] lo_w;
    logic [SIZE_W-1:0] pad_w;
    logic [SIZE_W-1:0] ends;
    lo_w  = SIZE_W'(lo);
    pad_w = SIZE_W'(pad);
    ends  = SIZE_W'(hi) + pad_w;
    res.start = (lo_w > pad_w) ? (lo_w - pad_w) : '0;
    if (ends >= extent) begin
      res.size = extent - SIZE_W'(1) - res.start;
    end else begin
      res.size = ends - res.start;
    end
    return res;
  endfunction

endpackage

// ===== rtl/bbc_stream_if.sv =====
// ---------------------------------------------------------------------------
// bbc_stream_if: valid/ready channel
// Carries one payload per transaction; source drives valid and data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/bbc_track.sv =====
// ---------------------------------------------------------------------------
// bbc_track: raster counters and extreme tracking
// Holds the configuration registers, walks column/row counters and keeps the
// least and greatest column and row of set pixels; latches a frame summary
// after the last pixel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_track #(
  parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bbc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bbc_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                         pix_fire,
  input  logic                         pixel_on,
  output logic                         snap_valid,
  input  logic                         snap_ready,
  output bbc_pkg::snap_t               snap
);

  // Largest usable side and counter widths
  localparam int WCAP = (MAX_WIDTH  < bbc_pkg::HW_CAP) ? MAX_WIDTH  : bbc_pkg::HW_CAP;
  localparam int HCAP = (MAX_HEIGHT < bbc_pkg::HW_CAP) ? MAX_HEIGHT : bbc_pkg::HW_CAP;
  localparam int XW   = $clog2(WCAP);
  localparam int YW   = $clog2(HCAP);
  localparam logic [bbc_pkg::SIZE_W-1:0] WCAP_S = bbc_pkg::SIZE_W'(WCAP);
  localparam logic [bbc_pkg::SIZE_W-1:0] HCAP_S = bbc_pkg::SIZE_W'(HCAP);

  // Configuration registers
  logic [bbc_pkg::SIZE_W-1:0] frame_width_r;
  logic [bbc_pkg::SIZE_W-1:0] frame_height_r;
  logic [bbc_pkg::PAD_W-1:0]  crop_padding_r;

  // Tracking state
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [XW-1:0] lc_r, lc_nxt, gc_r, gc_nxt;
  logic [YW-1:0] lr_r, lr_nxt, gr_r, gr_nxt;

  logic                       snap_v_r;
  bbc_pkg::snap_t             snap_r;

  logic [bbc_pkg::SIZE_W-1:0] w_eff, h_eff;
  logic [bbc_pkg::SIZE_W-1:0] w_new, h_new;
  logic [XW-1:0]              lc_upd, gc_upd;
  logic [YW-1:0]              lr_upd, gr_upd;
  logic                       col_last, frame_last;
  logic                       size_write;

  assign w_eff = bbc_pkg::limit_size(frame_width_r,  WCAP_S);
  assign h_eff = bbc_pkg::limit_size(frame_height_r, HCAP_S);

  // Size the frame restarts with after a size write
  always_comb begin
    w_new = w_eff;
    h_new = h_eff;
    if (cfg_we && cfg_index == bbc_pkg::REG_FRAME_WIDTH) begin
      w_new = bbc_pkg::limit_size(cfg_wdata, WCAP_S);
    end
    if (cfg_we && cfg_index == bbc_pkg::REG_FRAME_HEIGHT) begin
      h_new = bbc_pkg::limit_size(cfg_wdata, HCAP_S);
    end
  end

  assign size_write = cfg_we && (cfg_index == bbc_pkg::REG_FRAME_WIDTH ||
                                 cfg_index == bbc_pkg::REG_FRAME_HEIGHT);

  // Extremes including the current pixel, each compare on its own
  always_comb begin
    lc_upd = lc_r;
    gc_upd = gc_r;
    lr_upd = lr_r;
    gr_upd = gr_r;
    if (pixel_on) begin
      if (col_r < lc_r) lc_upd = col_r;
      if (col_r > gc_r) gc_upd = col_r;
      if (row_r < lr_r) lr_upd = row_r;
      if (row_r > gr_r) gr_upd = row_r;
    end
  end

  assign col_last   = (bbc_pkg::SIZE_W'(col_r) + 1'b1) >= w_eff;
  assign frame_last = col_last && ((bbc_pkg::SIZE_W'(row_r) + 1'b1) >= h_eff);

  // Next state of counters and extremes
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    lc_nxt  = lc_r;
    gc_nxt  = gc_r;
    lr_nxt  = lr_r;
    gr_nxt  = gr_r;
    if (size_write || (pix_fire && frame_last)) begin
      col_nxt = '0;
      row_nxt = '0;
      lc_nxt  = XW'(w_new - 1'b1);
      gc_nxt  = '0;
      lr_nxt  = YW'(h_new - 1'b1);
      gr_nxt  = '0;
    end else if (pix_fire) begin
      lc_nxt = lc_upd;
      gc_nxt = gc_upd;
      lr_nxt = lr_upd;
      gr_nxt = gr_upd;
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // Configuration and tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbc_pkg::RST_FRAME_WIDTH;
      frame_height_r <= bbc_pkg::RST_FRAME_HEIGHT;
      crop_padding_r <= bbc_pkg::RST_CROP_PADDING;
      col_r <= '0;
      row_r <= '0;
      lc_r  <= XW'(bbc_pkg::limit_size(bbc_pkg::RST_FRAME_WIDTH, WCAP_S) - 1'b1);
      gc_r  <= '0;
      lr_r  <= YW'(bbc_pkg::limit_size(bbc_pkg::RST_FRAME_HEIGHT, HCAP_S) - 1'b1);
      gr_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == bbc_pkg::REG_FRAME_WIDTH) frame_width_r <= cfg_wdata;
      if (cfg_we && cfg_index == bbc_pkg::REG_FRAME_HEIGHT) frame_height_r <= cfg_wdata;
      if (cfg_we && cfg_index == bbc_pkg::REG_CROP_PADDING) begin
        crop_padding_r <= cfg_wdata[bbc_pkg::PAD_W-1:0];
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      lc_r  <= lc_nxt;
      gc_r  <= gc_nxt;
      lr_r  <= lr_nxt;
      gr_r  <= gr_nxt;
    end
  end

  // Frame summary stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (pix_fire && frame_last) begin
      snap_v_r <= 1'b1;
    end else if (snap_ready) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire && frame_last) begin
      snap_r.least_column    <= bbc_pkg::COORD_W'(lc_upd);
      snap_r.greatest_column <= bbc_pkg::COORD_W'(gc_upd);
      snap_r.least_row       <= bbc_pkg::COORD_W'(lr_upd);
      snap_r.greatest_row    <= bbc_pkg::COORD_W'(gr_upd);
      snap_r.width           <= w_eff;
      snap_r.height          <= h_eff;
      snap_r.padding         <= crop_padding_r;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  // Counters stay inside the frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    bbc_pkg::SIZE_W'(col_r) < w_eff)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    bbc_pkg::SIZE_W'(row_r) < h_eff)
    else $error("row counter beyond frame height");

  // Last pixel restarts the raster and raises the summary
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pix_fire && frame_last |=> col_r == '0 && row_r == '0 && gc_r == '0 && snap_v_r)
    else $error("frame end did not restart tracking");

endmodule

// ===== rtl/bbc_pad.sv =====
// ---------------------------------------------------------------------------
// bbc_pad: padding, clamping and result register
// Turns a frame summary into a padded crop box and holds it until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_pad (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_valid,
  output logic           snap_ready,
  input  bbc_pkg::snap_t snap,
  output logic           box_valid,
  input  logic           box_ready,
  output bbc_pkg::box_t  box
);

  logic           box_v_r;
  bbc_pkg::box_t  box_r, box_nxt;
  bbc_pkg::axis_t ax, ay;
  logic           found;

  // Result register can take a summary when empty or being drained
  assign snap_ready = !box_v_r || box_ready;

  assign found = (snap.greatest_column != '0) && (snap.greatest_row != '0);
  assign ax = bbc_pkg::pad_axis(snap.least_column, snap.greatest_column,
                                snap.width, snap.padding);
  assign ay = bbc_pkg::pad_axis(snap.least_row, snap.greatest_row,
                                snap.height, snap.padding);

  // Box fields; all zero when nothing was found
  always_comb begin
    box_nxt = '0;
    if (found) begin
      box_nxt.object_found = 1'b1;
      box_nxt.crop_x       = ax.start[bbc_pkg::COORD_W-1:0];
      box_nxt.crop_y       = ay.start[bbc_pkg::COORD_W-1:0];
      box_nxt.crop_width   = ax.size[bbc_pkg::COORD_W-1:0];
      box_nxt.crop_height  = ay.size[bbc_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_v_r <= 1'b0;
    end else if (snap_ready) begin
      box_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      box_r <= box_nxt;
    end
  end

  assign box_valid = box_v_r;
  assign box       = box_r;

  // A moved summary always shows up as a result next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && snap_ready |=> box_v_r)
    else $error("summary lost in padding stage");

  // An unmoved, stalled result keeps its fields
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    box_v_r && !box_ready |=> box_v_r && $stable(box_r))
    else $error("stalled result changed");

endmodule

// ===== rtl/binary_bounding_box_crop.sv =====
// ---------------------------------------------------------------------------
// binary_bounding_box_crop: bounding box of set pixels with padded crop
// After the last pixel of a frame is accepted, the result passes the tracker
// summary register, then the padding/result register. Counters and extremes
// are registered; throughput is one pixel per cycle unless the input stalls.
// Reset (synchronous, rst_n low): registers to 320 x 240 with padding 30,
// counters and extremes to a fresh frame, no result pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_bounding_box_crop #(
  parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bbc_pkg::SIZE_W-1:0] cfg_wdata,
  bbc_stream_if.sink                 in_ch,
  bbc_stream_if.source               out_ch
);

  logic           snap_valid;
  logic           snap_ready;
  logic           pix_fire;
  bbc_pkg::snap_t snap;
  bbc_pkg::pixel_t pix;
  bbc_pkg::box_t   box;

  // Input stalls only when a summary waits on a full, blocked result register
  assign in_ch.ready = !snap_valid || snap_ready;
  assign pix_fire    = in_ch.valid && in_ch.ready;
  assign pix         = in_ch.data;

  bbc_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pix_fire   (pix_fire),
    .pixel_on   (pix.pixel_on),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  bbc_pad u_pad (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .box_valid  (out_ch.valid),
    .box_ready  (out_ch.ready),
    .box        (box)
  );

  assign out_ch.data = box;

endmodule
